// File: src/bole_pkg.sv
// Shared types and constants for the bounded ordered list engine.
// Used by the front decoder, the command queue, the back executor and the top level.
// Depends on nothing.
package bole_pkg;

    localparam int CAPACITY    = 16;
    localparam int CNT_W       = $clog2(CAPACITY + 1);
    localparam int IDX_W       = $clog2(CAPACITY);
    localparam int OPC_W       = 3;
    localparam int VALUE_W     = 32;
    localparam int POS_W       = 8;
    localparam int STATUS_W    = 2;
    localparam int COUNT_W     = 5;
    localparam int CMP_W       = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [OPC_W-1:0] OPC_INS_FRONT = 3'd0;
    localparam logic [OPC_W-1:0] OPC_APPEND    = 3'd1;
    localparam logic [OPC_W-1:0] OPC_INS_AFTER = 3'd2;
    localparam logic [OPC_W-1:0] OPC_REMOVE    = 3'd3;
    localparam logic [OPC_W-1:0] OPC_SEARCH    = 3'd4;
    localparam logic [OPC_W-1:0] OPC_DUMP      = 3'd5;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        CMD_INS_FRONT,
        CMD_APPEND,
        CMD_INS_AFTER,
        CMD_REMOVE,
        CMD_SEARCH,
        CMD_DUMP,
        CMD_NOP
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t                 kind;
        logic signed [VALUE_W-1:0] value;
        logic [POS_W-1:0]          position;
    } cmd_t;

    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } queue_head_t;

endpackage

// File: src/bounded_ordered_list_engine_core.sv
// Top level of the bounded ordered list engine.
// Depends on bole_pkg, bole_front, bole_queue and bole_back.
//
// The slave stream carries one command per transfer: the opcode in tuser, the value
// and the 1-based position in tdata. The master stream returns results; every command
// gives one result, except a dump of a non-empty list, which gives one result per
// entry with tlast on the final one and tuser set while tdata holds an entry.
// A decoder takes commands into a two-entry queue; the executor pulls them one at a
// time and owns the shifting entry store and the result register.
// Insert, append, insert after, remove and unused opcodes finish as the executor pulls
// them from the queue, and their result is registered for the output.
// Search pulls the command and then walks the stored entries one per cycle through a
// single compare (an empty list is answered as the command is pulled); a dump gives
// one result per cycle after the pull while the output is not stalled.
// The input side keeps accepting while the queue has room, even when the output is
// stalled; a stalled result holds in the output register and the executor waits.
// Reset empties the list and the queue; the store itself is not cleared, since only
// entries below the count are ever read, so the block is ready right after reset.
module bounded_ordered_list_engine_core
    import bole_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    // value [31:0], position [39:32]
    input  logic [39:0]      s_axis_tdata,
    // opcode [2:0]
    input  logic [OPC_W-1:0] s_axis_tuser,
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    // status [1:0], found [2], element [34:3], count [39:35],
    // empty_res [40], full_res [41], zero [47:42]
    output logic [47:0]      m_axis_tdata,
    // element_valid [0]
    output logic             m_axis_tuser,
    output logic             m_axis_tlast
);

    logic        queue_ready;
    logic        push;
    cmd_t        push_cmd;
    logic        pop;
    queue_head_t head;

    bole_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .queue_ready   (queue_ready),
        .push          (push),
        .push_cmd      (push_cmd)
    );

    bole_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .ready    (queue_ready),
        .pop      (pop),
        .head     (head)
    );

    bole_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head          (head),
        .pop           (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

// File: src/bole_front.sv
// Front end of the list engine: takes input transfers and decodes the opcode.
// Depends on bole_pkg; feeds bole_queue.
module bole_front
    import bole_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    // value [31:0], position [39:32]
    input  logic [39:0]         s_axis_tdata,
    // opcode [2:0]
    input  logic [OPC_W-1:0]    s_axis_tuser,
    input  logic                queue_ready,
    output logic                push,
    output cmd_t                push_cmd
);

    cmd_kind_t kind;

    always_comb
    begin
        unique case (s_axis_tuser)
            OPC_INS_FRONT: kind = CMD_INS_FRONT;
            OPC_APPEND:    kind = CMD_APPEND;
            OPC_INS_AFTER: kind = CMD_INS_AFTER;
            OPC_REMOVE:    kind = CMD_REMOVE;
            OPC_SEARCH:    kind = CMD_SEARCH;
            OPC_DUMP:      kind = CMD_DUMP;
            default:       kind = CMD_NOP;
        endcase
    end

    assign s_axis_tready     = queue_ready;
    assign push              = s_axis_tvalid && queue_ready;
    assign push_cmd.kind     = kind;
    assign push_cmd.value    = s_axis_tdata[VALUE_W-1:0];
    assign push_cmd.position = s_axis_tdata[VALUE_W+POS_W-1:VALUE_W];

    assert property (@(posedge clk) disable iff (!rst_n)
        push |-> s_axis_tready)
        else $error("Front pushed while the queue was full.");

endmodule

// File: src/bole_queue.sv
// Short command queue between the front decoder and the back executor.
// Depends on bole_pkg.
module bole_queue
    import bole_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  cmd_t        push_cmd,
    output logic        ready,
    input  logic        pop,
    output queue_head_t head
);

    cmd_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] fill_reg;
    logic [QCNT_W-1:0] fill_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    assign ready      = (fill_reg != QCNT_W'(QUEUE_DEPTH));
    assign head.valid = (fill_reg != '0);
    assign head.cmd   = slot_reg[rd_ptr_reg];

endmodule

// File: src/bole_back.sv
// Back end of the list engine: runs queued commands on the shifting entry store
// and drives the registered result channel. Depends on bole_pkg.
module bole_back
    import bole_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  queue_head_t                head,
    output logic                       pop,
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    // status [1:0], found [2], element [34:3], count [39:35],
    // empty_res [40], full_res [41], zero [47:42]
    output logic [47:0]                m_axis_tdata,
    // element_valid [0]
    output logic                       m_axis_tuser,
    output logic                       m_axis_tlast
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_DUMP
    } state_t;

    state_t                    state_reg;
    state_t                    state_next;
    logic [CNT_W-1:0]          count_reg;
    logic [CNT_W-1:0]          count_next;
    logic [IDX_W-1:0]          idx_reg;
    logic [IDX_W-1:0]          idx_next;
    logic                      hit_reg;
    logic                      hit_next;
    logic signed [VALUE_W-1:0] key_reg;
    logic signed [VALUE_W-1:0] key_next;

    logic                      valid_reg;
    logic                      valid_next;
    status_t                   status_reg;
    status_t                   status_next;
    logic                      found_reg;
    logic                      found_next;
    logic signed [VALUE_W-1:0] element_reg;
    logic signed [VALUE_W-1:0] element_next;
    logic                      ev_reg;
    logic                      ev_next;
    logic                      last_reg;
    logic                      last_next;
    logic [CNT_W-1:0]          rcount_reg;
    logic [CNT_W-1:0]          rcount_next;

    logic signed [VALUE_W-1:0] store_reg [CAPACITY];
    logic signed [VALUE_W-1:0] below [CAPACITY];
    logic signed [VALUE_W-1:0] above [CAPACITY];

    cmd_t                      cmd;
    logic                      out_free;
    logic                      emit;
    logic                      is_full;
    logic [CMP_W-1:0]          p_ext;
    logic [CMP_W-1:0]          n_ext;
    logic [CMP_W-1:0]          ins_wide;
    logic [IDX_W-1:0]          ins_idx;
    logic [IDX_W-1:0]          rem_idx;
    logic                      after_bad;
    logic                      rem_bad;
    logic                      ins_en;
    logic                      rem_en;
    logic                      at_last;
    logic signed [VALUE_W-1:0] cur;

    assign cmd      = head.cmd;
    assign out_free = !valid_reg || m_axis_tready;
    assign is_full  = (count_reg >= CNT_W'(CAPACITY));
    assign p_ext    = CMP_W'(cmd.position);
    assign n_ext    = CMP_W'(count_reg);
    assign cur      = store_reg[idx_reg];
    assign at_last  = ((CNT_W'(idx_reg) + 1'b1) == count_reg);

    always_comb
    begin
        case (cmd.kind)
            CMD_INS_FRONT: ins_wide = '0;
            CMD_APPEND:    ins_wide = n_ext;
            default:
            begin
                if (p_ext <= CMP_W'(1))
                begin
                    ins_wide = (count_reg != '0) ? CMP_W'(1) : '0;
                end
                else
                begin
                    ins_wide = p_ext;
                end
            end
        endcase
        if (ins_wide > n_ext)
        begin
            ins_wide = n_ext;
        end
    end

    assign ins_idx   = IDX_W'(ins_wide);
    assign rem_idx   = IDX_W'(p_ext - 1'b1);
    assign after_bad = (p_ext > n_ext + 1'b1);
    assign rem_bad   = (p_ext == '0) || (p_ext > n_ext);

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        idx_next     = idx_reg;
        hit_next     = hit_reg;
        key_next     = key_reg;
        valid_next   = valid_reg && !m_axis_tready;
        status_next  = status_reg;
        found_next   = found_reg;
        element_next = element_reg;
        ev_next      = ev_reg;
        last_next    = last_reg;
        pop          = 1'b0;
        emit         = 1'b0;
        ins_en       = 1'b0;
        rem_en       = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (head.valid && out_free)
                begin
                    pop          = 1'b1;
                    status_next  = ST_DONE;
                    found_next   = 1'b0;
                    element_next = '0;
                    ev_next      = 1'b0;
                    last_next    = 1'b1;
                    unique case (cmd.kind) inside
                        CMD_INS_FRONT, CMD_APPEND, CMD_INS_AFTER:
                        begin
                            emit = 1'b1;
                            if (is_full)
                            begin
                                status_next = ST_FULL;
                            end
                            else if (cmd.kind == CMD_INS_AFTER && after_bad)
                            begin
                                status_next = ST_RANGE;
                            end
                            else
                            begin
                                ins_en     = 1'b1;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        CMD_REMOVE:
                        begin
                            emit = 1'b1;
                            if (rem_bad)
                            begin
                                status_next = ST_RANGE;
                            end
                            else
                            begin
                                rem_en     = 1'b1;
                                count_next = count_reg - 1'b1;
                            end
                        end
                        CMD_SEARCH:
                        begin
                            if (count_reg == '0)
                            begin
                                emit = 1'b1;
                            end
                            else
                            begin
                                key_next   = cmd.value;
                                idx_next   = '0;
                                hit_next   = 1'b0;
                                state_next = S_SEARCH;
                            end
                        end
                        CMD_DUMP:
                        begin
                            if (count_reg == '0)
                            begin
                                emit = 1'b1;
                            end
                            else
                            begin
                                idx_next   = '0;
                                state_next = S_DUMP;
                            end
                        end
                        default:
                        begin
                            emit = 1'b1;
                        end
                    endcase
                end
            end
            S_SEARCH:
            begin
                if (!at_last)
                begin
                    hit_next = hit_reg || (cur == key_reg);
                    idx_next = idx_reg + 1'b1;
                end
                else if (out_free)
                begin
                    emit         = 1'b1;
                    status_next  = ST_DONE;
                    found_next   = hit_reg || (cur == key_reg);
                    element_next = '0;
                    ev_next      = 1'b0;
                    last_next    = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_DUMP:
            begin
                if (out_free)
                begin
                    emit         = 1'b1;
                    status_next  = ST_DONE;
                    found_next   = 1'b0;
                    element_next = cur;
                    ev_next      = 1'b1;
                    last_next    = at_last;
                    idx_next     = idx_reg + 1'b1;
                    if (at_last)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        if (emit)
        begin
            valid_next = 1'b1;
        end
        rcount_next = emit ? count_next : rcount_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            idx_reg     <= '0;
            hit_reg     <= 1'b0;
            key_reg     <= '0;
            valid_reg   <= 1'b0;
            status_reg  <= ST_DONE;
            found_reg   <= 1'b0;
            element_reg <= '0;
            ev_reg      <= 1'b0;
            last_reg    <= 1'b0;
            rcount_reg  <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            idx_reg     <= idx_next;
            hit_reg     <= hit_next;
            key_reg     <= key_next;
            valid_reg   <= valid_next;
            status_reg  <= status_next;
            found_reg   <= found_next;
            element_reg <= element_next;
            ev_reg      <= ev_next;
            last_reg    <= last_next;
            rcount_reg  <= rcount_next;
        end
    end

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        if (i == 0)
        begin : g_head
            assign below[i] = '0;
        end
        else
        begin : g_below
            assign below[i] = store_reg[i-1];
        end
        if (i == CAPACITY - 1)
        begin : g_tail
            assign above[i] = store_reg[i];
        end
        else
        begin : g_above
            assign above[i] = store_reg[i+1];
        end

        always_ff @(posedge clk)
        begin
            if (ins_en)
            begin
                if (IDX_W'(i) == ins_idx)
                begin
                    store_reg[i] <= cmd.value;
                end
                else if (IDX_W'(i) > ins_idx)
                begin
                    store_reg[i] <= below[i];
                end
            end
            else if (rem_en && IDX_W'(i) >= rem_idx)
            begin
                store_reg[i] <= above[i];
            end
        end
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tuser  = ev_reg;
    assign m_axis_tlast  = last_reg;
    assign m_axis_tdata  = {6'b0,
                            (rcount_reg == CNT_W'(CAPACITY)),
                            (rcount_reg == '0),
                            COUNT_W'(rcount_reg),
                            element_reg,
                            found_reg,
                            status_reg};

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("Entry count went beyond the capacity.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> (count_reg != '0))
        else $error("Walk started over an empty list.");

    assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (state_reg == S_IDLE && head.valid))
        else $error("Command taken from the queue outside the idle state.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (ins_en || rem_en) |=> (valid_reg && last_reg && !ev_reg))
        else $error("List update gave no single closing result.");

endmodule

// File: sim/bounded_ordered_list_engine_core_test.sv
// Self-checking testbench for the bounded ordered list engine core.
// A clocked driver feeds list commands from a backlog, a shadow list predicts every reply,
// and a clocked monitor compares each reply field by field. Depends on bole_pkg and bounded_ordered_list_engine_core.
module bounded_ordered_list_engine_core_test;
    import bole_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [OPC_W-1:0] OPC_SPARE_6 = 3'd6;
    localparam logic [OPC_W-1:0] OPC_SPARE_7 = 3'd7;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int HOLD_AFTER_ITEMS = 40;
    localparam int CALM_TAIL_ITEMS = 40;

    typedef struct {
        logic [OPC_W-1:0]          op;
        logic signed [VALUE_W-1:0] value;
        logic [POS_W-1:0]          position;
        logic                      drain_first;
    } list_cmd_t;

    typedef struct {
        status_t                   status;
        logic                      found;
        logic signed [VALUE_W-1:0] element;
        logic                      element_valid;
        logic                      last;
        logic [COUNT_W-1:0]        count;
        logic                      empty_res;
        logic                      full_res;
    } list_reply_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [39:0] s_axis_tdata = '0;
    logic [OPC_W-1:0] s_axis_tuser = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;
    logic m_axis_tuser;
    logic m_axis_tlast;

    list_cmd_t command_backlog[$];
    list_reply_t pending_replies[$];
    logic signed [VALUE_W-1:0] shadow_entries[CAPACITY];
    int unsigned shadow_len = 0;

    int sent_items = 0;
    int replies_predicted = 0;
    int replies_checked = 0;
    int mismatches = 0;
    int full_rejects = 0;
    int range_rejects = 0;
    int listed_entries = 0;
    int search_hits = 0;
    logic calm = 1'b0;

    bounded_ordered_list_engine_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #1 clk = ~clk;

    task automatic apply_list_command(input logic [OPC_W-1:0] op,
                                      input logic signed [VALUE_W-1:0] v,
                                      input logic [POS_W-1:0] p);
        list_reply_t batch[$];
        list_reply_t r;
        int unsigned n;
        int unsigned idx;
        int unsigned i;
        logic hit;
        logic do_place;
        n = shadow_len;
        hit = 1'b0;
        do_place = 1'b0;
        idx = 0;
        r.status = ST_DONE;
        r.found = 1'b0;
        r.element = '0;
        r.element_valid = 1'b0;
        r.last = 1'b1;
        case (op) inside
            OPC_INS_FRONT, OPC_APPEND:
            begin
                if (n >= CAPACITY)
                    r.status = ST_FULL;
                else
                begin
                    idx = (op == OPC_INS_FRONT) ? 0 : n;
                    do_place = 1'b1;
                end
            end
            OPC_INS_AFTER:
            begin
                if (n >= CAPACITY)
                    r.status = ST_FULL;
                else if (int'(p) > n + 1)
                    r.status = ST_RANGE;
                else
                begin
                    idx = (p <= 1) ? ((n > 0) ? 1 : 0) : int'(p);
                    if (idx > n)
                        idx = n;
                    do_place = 1'b1;
                end
            end
            OPC_REMOVE:
            begin
                if (p == 0 || int'(p) > n)
                    r.status = ST_RANGE;
                else
                begin
                    for (i = p - 1; i + 1 < n; i++)
                        shadow_entries[i] = shadow_entries[i + 1];
                    shadow_len = n - 1;
                end
            end
            OPC_SEARCH:
            begin
                for (i = 0; i < n; i++)
                    if (shadow_entries[i] == v)
                        hit = 1'b1;
                r.found = hit;
            end
            OPC_DUMP:
            begin
                for (i = 0; i + 1 < n; i++)
                begin
                    r.element = shadow_entries[i];
                    r.element_valid = 1'b1;
                    r.last = 1'b0;
                    batch.push_back(r);
                end
                if (n > 0)
                begin
                    r.element = shadow_entries[n - 1];
                    r.element_valid = 1'b1;
                    r.last = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
        if (do_place)
        begin
            for (i = n; i > idx; i--)
                shadow_entries[i] = shadow_entries[i - 1];
            shadow_entries[idx] = v;
            shadow_len = n + 1;
        end
        batch.push_back(r);
        foreach (batch[k])
        begin
            batch[k].count = shadow_len[COUNT_W-1:0];
            batch[k].empty_res = (shadow_len == 0);
            batch[k].full_res = (shadow_len == CAPACITY);
            pending_replies.push_back(batch[k]);
        end
        replies_predicted += batch.size();
    endtask

    function automatic string describe(input list_reply_t r);
        return $sformatf({"status=%0d found=%0d element=%h valid=%0d last=%0d ",
                          "count=%0d empty=%0d full=%0d"},
                         r.status, r.found, r.element, r.element_valid, r.last, r.count,
                         r.empty_res, r.full_res);
    endfunction

    task automatic line_up(input logic [OPC_W-1:0] op, input logic signed [VALUE_W-1:0] v,
                           input logic [POS_W-1:0] p, input logic drain_first);
        list_cmd_t c;
        c.op = op;
        c.value = v;
        c.position = p;
        c.drain_first = drain_first;
        command_backlog.push_back(c);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        logic next_valid;
        int source_gap;
        list_cmd_t c;
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            source_gap = 0;
        end
        else
        begin
            next_valid = s_axis_tvalid;
            if (s_axis_tvalid && s_axis_tready)
            begin
                apply_list_command(s_axis_tuser, s_axis_tdata[31:0], s_axis_tdata[39:32]);
                sent_items <= sent_items + 1;
                next_valid = 1'b0;
                if (!calm && $urandom_range(0, 2) == 0)
                    source_gap = $urandom_range(1, 10);
            end
            if (!next_valid)
            begin
                if (source_gap > 0)
                    source_gap--;
                else if (command_backlog.size() > 0 &&
                         !(command_backlog[0].drain_first && replies_predicted != replies_checked))
                begin
                    c = command_backlog.pop_front();
                    s_axis_tdata <= {c.position, c.value};
                    s_axis_tuser <= c.op;
                    next_valid = 1'b1;
                end
            end
            s_axis_tvalid <= next_valid;
            calm <= (command_backlog.size() < CALM_TAIL_ITEMS);
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        logic next_ready;
        int sink_gap;
        int hold_left;
        logic long_hold_done;
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            sink_gap = 0;
            hold_left = 0;
            long_hold_done = 1'b0;
        end
        else
        begin
            next_ready = 1'b1;
            if (!long_hold_done && sent_items >= HOLD_AFTER_ITEMS)
            begin
                long_hold_done = 1'b1;
                hold_left = LONG_HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                next_ready = 1'b0;
            end
            else if (sink_gap > 0)
            begin
                sink_gap--;
                next_ready = 1'b0;
            end
            else if (!calm && $urandom_range(0, 3) == 0)
            begin
                sink_gap = $urandom_range(1, 10) - 1;
                next_ready = 1'b0;
            end
            m_axis_tready <= next_ready;
        end
    end

    always @(posedge clk)
    begin
        list_reply_t got;
        list_reply_t want;
        logic bad;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.status = status_t'(m_axis_tdata[1:0]);
            got.found = m_axis_tdata[2];
            got.element = m_axis_tdata[34:3];
            got.element_valid = m_axis_tuser;
            got.last = m_axis_tlast;
            got.count = m_axis_tdata[39:35];
            got.empty_res = m_axis_tdata[40];
            got.full_res = m_axis_tdata[41];
            replies_checked <= replies_checked + 1;
            if (got.status == ST_FULL)
                full_rejects <= full_rejects + 1;
            if (got.status == ST_RANGE)
                range_rejects <= range_rejects + 1;
            if (got.element_valid)
                listed_entries <= listed_entries + 1;
            if (got.found)
                search_hits <= search_hits + 1;
            if (pending_replies.size() == 0)
            begin
                if (mismatches < 10)
                    $display("unexpected reply: %s", describe(got));
                mismatches <= mismatches + 1;
            end
            else
            begin
                want = pending_replies.pop_front();
                bad = (got.status !== want.status) || (got.found !== want.found) ||
                      (got.element !== want.element) ||
                      (got.element_valid !== want.element_valid) ||
                      (got.last !== want.last) || (got.count !== want.count) ||
                      (got.empty_res !== want.empty_res) ||
                      (got.full_res !== want.full_res) || (m_axis_tdata[47:42] !== '0);
                if (bad)
                begin
                    if (mismatches < 10)
                    begin
                        $display("mismatch at %0t: expected %s", $realtime, describe(want));
                        $display("            got %s pad=%h", describe(got), m_axis_tdata[47:42]);
                    end
                    mismatches <= mismatches + 1;
                end
            end
        end
    end

    initial
    begin
        logic signed [VALUE_W-1:0] pool[8];
        logic [OPC_W-1:0] op;
        logic signed [VALUE_W-1:0] v;
        logic [POS_W-1:0] p;
        int roll;
        int phase_kind;
        int leftover;

        pool = '{32'sh80000000, 32'sh7FFFFFFF, 32'sd0, -32'sd1, 32'sd1, 32'sd42, -32'sd42,
                 32'sh55555555};

        line_up(OPC_DUMP, 32'sd0, 8'd0, 1'b1);
        line_up(OPC_REMOVE, 32'sd0, 8'd0, 1'b0);
        line_up(OPC_REMOVE, 32'sd0, 8'd1, 1'b0);
        line_up(OPC_SEARCH, 32'sd0, 8'd0, 1'b0);
        line_up(OPC_INS_AFTER, 32'sh80000000, 8'd0, 1'b0);
        line_up(OPC_INS_AFTER, 32'sh7FFFFFFF, 8'd1, 1'b0);
        line_up(OPC_INS_FRONT, -32'sd1, 8'd0, 1'b0);
        line_up(OPC_APPEND, 32'sd0, 8'd255, 1'b0);
        line_up(OPC_INS_AFTER, 32'sh55555555, 8'd5, 1'b0);
        line_up(OPC_INS_AFTER, 32'shAAAAAAAA, 8'd7, 1'b0);
        line_up(OPC_INS_AFTER, 32'shAAAAAAAA, 8'd255, 1'b0);
        line_up(OPC_INS_AFTER, 32'sd12345, 8'd3, 1'b0);
        line_up(OPC_SEARCH, 32'sh7FFFFFFF, 8'd0, 1'b0);
        line_up(OPC_SEARCH, 32'sh80000000, 8'd0, 1'b0);
        line_up(OPC_SEARCH, 32'sd1, 8'd0, 1'b0);
        line_up(OPC_DUMP, 32'sd0, 8'd0, 1'b0);
        line_up(OPC_REMOVE, 32'sd0, 8'd255, 1'b0);
        line_up(OPC_REMOVE, 32'sd0, 8'd6, 1'b0);
        line_up(OPC_REMOVE, 32'sd0, 8'd1, 1'b0);
        line_up(OPC_SPARE_6, 32'sd0, 8'd0, 1'b0);
        line_up(OPC_SPARE_7, -32'sd1, 8'd255, 1'b0);
        line_up(OPC_DUMP, 32'sd0, 8'd0, 1'b0);

        // Phases alternate between growing the list to full, mixed traffic and draining it.
        for (int ph = 0; ph < 9; ph++)
        begin
            phase_kind = ph % 3;
            for (int k = 0; k < 30; k++)
            begin
                roll = $urandom_range(0, 99);
                if (phase_kind == 0)
                    op = (roll < 35) ? OPC_INS_FRONT : (roll < 60) ? OPC_APPEND :
                         (roll < 85) ? OPC_INS_AFTER : (roll < 90) ? OPC_REMOVE :
                         (roll < 95) ? OPC_SEARCH : OPC_DUMP;
                else if (phase_kind == 1)
                    op = (roll < 15) ? OPC_INS_FRONT : (roll < 30) ? OPC_APPEND :
                         (roll < 45) ? OPC_INS_AFTER : (roll < 62) ? OPC_REMOVE :
                         (roll < 82) ? OPC_SEARCH : (roll < 95) ? OPC_DUMP :
                         OPC_W'($urandom_range(0, 7));
                else
                    op = (roll < 60) ? OPC_REMOVE : (roll < 75) ? OPC_SEARCH :
                         (roll < 85) ? OPC_DUMP : (roll < 95) ? OPC_APPEND :
                         OPC_W'($urandom_range(0, 7));
                v = ($urandom_range(0, 9) < 6) ? pool[$urandom_range(0, 7)] : $urandom;
                if (op == OPC_REMOVE)
                    p = ($urandom_range(0, 9) < 7) ? POS_W'($urandom_range(1, 3)) :
                                                     POS_W'($urandom_range(0, 255));
                else if (op == OPC_INS_AFTER)
                    p = ($urandom_range(0, 9) < 8) ? POS_W'($urandom_range(0, 17)) :
                                                     POS_W'($urandom_range(0, 255));
                else
                    p = POS_W'($urandom_range(0, 255));
                line_up(op, v, p, k == 0 && ph < 8);
            end
        end

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        while (command_backlog.size() > 0 || s_axis_tvalid)
            @(posedge clk);
        while (pending_replies.size() > 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        leftover = pending_replies.size();

        $display("Ran %0d commands and checked %0d replies, with %0d full and %0d range %s",
                 sent_items, replies_checked, full_rejects, range_rejects, "rejections,");
        $display("%0d entries listed by dumps and %0d search hits; %0d mismatches.",
                 listed_entries, search_hits, mismatches + leftover);
        if (mismatches == 0 && leftover == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        #1000000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
